FILE: hw/rtl/ps2_mouse_packet_tracker_assert.svh
// Assertion macros for the PS/2 mouse packet tracker.
// No dependencies; included by the top level.
`ifndef PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH
`define PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH

// Overlapping implication, checked at every rising edge outside reset.
`define PMT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Non-overlapping implication: the consequent is checked at the next rising edge.
`define PMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/pmt_pkg.sv
// Shared types and constants for the PS/2 mouse packet tracker.
// No dependencies.
`default_nettype none
package pmt_pkg;

    localparam int unsigned CFG_BITS  = 13;
    localparam int unsigned IDX_BITS  = 2;
    localparam logic [IDX_BITS-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [IDX_BITS-1:0] CFG_HEIGHT = 2'd1;

    localparam logic [CFG_BITS-1:0] WIDTH_RST  = 13'd640;
    localparam logic [CFG_BITS-1:0] HEIGHT_RST = 13'd480;
    localparam logic [CFG_BITS-1:0] SIZE_MAX   = 13'd4096;
    localparam logic [CFG_BITS-1:0] WIDTH_MIN  = 13'd16;
    localparam logic [CFG_BITS-1:0] HEIGHT_MIN = 13'd24;
    localparam int unsigned X_MARGIN = 9;
    localparam int unsigned Y_MARGIN = 17;

    localparam int unsigned HDR_LEFT   = 0;
    localparam int unsigned HDR_RIGHT  = 1;
    localparam int unsigned HDR_MIDDLE = 2;
    localparam int unsigned HDR_SYNC   = 3;
    localparam int unsigned HDR_XSIGN  = 4;
    localparam int unsigned HDR_YSIGN  = 5;
    localparam int unsigned HDR_XOVF   = 6;
    localparam int unsigned HDR_YOVF   = 7;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_HDR,
        PH_X,
        PH_Y
    } t_phase;

    typedef struct packed {
        logic [7:0] hdr;
        logic [7:0] xb;
        logic [7:0] yb;
    } t_pkt;

    typedef struct packed {
        logic [11:0] cursor_x;
        logic [11:0] cursor_y;
        logic        left;
        logic        right;
        logic        middle;
    } t_res;

endpackage
`default_nettype wire

FILE: hw/rtl/ps2_mouse_packet_tracker.sv
// Top level of the PS/2 mouse packet tracker: config registers, framer,
// packet queue, position engine and result queue. Depends on pmt_pkg and the
// modules pmt_fifo, pmt_front, pmt_back, and the assertion header.
//
//  channel   | handshake           | payload
//  ----------+---------------------+---------------------------------------
//  bytes in  | push / full         | i_data_byte
//  results   | pop / empty         | o_cursor_x, o_cursor_y, o_*_button
//  config    | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// One byte a cycle while full is low; a completed packet is queued at the edge
// that takes the third byte. The position engine takes it once the result queue
// has room and queues its result for the result ports. Reset is synchronous
// and clears the phase, position and queue counts.
// full follows the two-entry packet queue, which backs up when pop is held low.
`default_nettype none
`include "ps2_mouse_packet_tracker_assert.svh"
module ps2_mouse_packet_tracker #(
    parameter int unsigned POS_BITS = 14
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [11:0]      o_cursor_x,
    output logic [11:0]      o_cursor_y,
    output logic             o_left_button,
    output logic             o_right_button,
    output logic             o_middle_button,
    input  wire logic        i_cfg_we,
    input  wire logic [pmt_pkg::IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [pmt_pkg::CFG_BITS-1:0] i_cfg_data
);
    import pmt_pkg::*;

    logic [CFG_BITS-1:0] r_width, r_height;
    logic  byte_ok, pkt_push, mid_empty, out_full, back_fire;
    t_pkt  pkt_in, pkt_out;
    t_res  res_in, res_out;

    assign byte_ok   = push && !full;
    assign back_fire = !mid_empty && !out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_WIDTH) r_width <= i_cfg_data;
            if (i_cfg_idx == CFG_HEIGHT) r_height <= i_cfg_data;
        end
    end

    pmt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (byte_ok),
        .i_byte     (i_data_byte),
        .o_pkt_push (pkt_push),
        .o_pkt      (pkt_in)
    );

    pmt_fifo #(.W($bits(t_pkt))) u_pkt_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (pkt_push),
        .i_data  (pkt_in),
        .o_full  (full),
        .i_pop   (back_fire),
        .o_data  (pkt_out),
        .o_empty (mid_empty)
    );

    pmt_back #(.POS_BITS(POS_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (back_fire),
        .i_pkt    (pkt_out),
        .i_width  (r_width),
        .i_height (r_height),
        .o_res    (res_in)
    );

    pmt_fifo #(.W($bits(t_res))) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_fire),
        .i_data  (res_in),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_cursor_x      = res_out.cursor_x;
    assign o_cursor_y      = res_out.cursor_y;
    assign o_left_button   = res_out.left;
    assign o_right_button  = res_out.right;
    assign o_middle_button = res_out.middle;

    `PMT_ASSERT_NEXT(a_pkt_queued, i_clk, i_rst_n, pkt_push && !full, !mid_empty, "packet lost")
    `PMT_ASSERT_NEXT(a_res_queued, i_clk, i_rst_n, back_fire, !empty, "result lost")
    `PMT_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, !back_fire && !(pop && !empty), empty == $past(empty), "result queue moved")
endmodule
`default_nettype wire

FILE: hw/rtl/pmt_fifo.sv
// Two-entry register queue used between front, back and result ports.
// No dependencies.
`default_nettype none
module pmt_fifo #(
    parameter int unsigned W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);
    logic [W-1:0] r_mem [2];
    logic         r_wr, r_rd;
    logic [1:0]   r_cnt, n_cnt;
    logic         do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) n_cnt = r_cnt + 2'd1;
        else if (do_pop && !do_push) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) r_wr <= !r_wr;
            if (do_pop) r_rd <= !r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end
endmodule
`default_nettype wire

FILE: hw/rtl/pmt_front.sv
// Byte framer: drops the first byte, syncs on header bytes, emits packets.
// Depends on pmt_pkg.
`default_nettype none
module pmt_front (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire logic [7:0] i_byte,
    output logic       o_pkt_push,
    output pmt_pkg::t_pkt o_pkt
);
    import pmt_pkg::*;

    t_phase     r_state, n_state;
    logic [7:0] r_hdr, r_xb;
    logic       capt_hdr, capt_x;

    always_comb begin
        n_state = r_state;
        if (i_valid) begin
            unique case (r_state)
                PH_SKIP: n_state = PH_HDR;
                PH_HDR:  n_state = i_byte[HDR_SYNC] ? PH_X : PH_HDR;
                PH_X:    n_state = PH_Y;
                PH_Y:    n_state = PH_HDR;
                default: n_state = PH_HDR;
            endcase
        end
    end

    always_comb begin
        capt_hdr   = i_valid && (r_state == PH_HDR) && i_byte[HDR_SYNC];
        capt_x     = i_valid && (r_state == PH_X);
        o_pkt_push = i_valid && (r_state == PH_Y);
        o_pkt.hdr  = r_hdr;
        o_pkt.xb   = r_xb;
        o_pkt.yb   = i_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PH_SKIP;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (capt_hdr) r_hdr <= i_byte;
        if (capt_x) r_xb <= i_byte;
    end
endmodule
`default_nettype wire

FILE: hw/rtl/pmt_back.sv
// Position engine: applies packet deltas, clamps to the screen, forms results.
// Depends on pmt_pkg.
`default_nettype none
module pmt_back #(
    parameter int unsigned POS_BITS = 14
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_fire,
    input  wire pmt_pkg::t_pkt i_pkt,
    input  wire logic [pmt_pkg::CFG_BITS-1:0] i_width,
    input  wire logic [pmt_pkg::CFG_BITS-1:0] i_height,
    output pmt_pkg::t_res o_res
);
    import pmt_pkg::*;

    localparam int unsigned S = POS_BITS + 2;

    logic [POS_BITS-1:0] r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    logic [CFG_BITS-1:0] w_sat, h_sat;
    logic [8:0]          x_mag, y_mag;
    logic signed [S-1:0] x_sum, y_sum;

    function automatic logic [CFG_BITS-1:0] sat_size(input logic [CFG_BITS-1:0] v,
                                                     input logic [CFG_BITS-1:0] lo);
        logic [CFG_BITS-1:0] s;
        s = v;
        if (s < lo) s = lo;
        if (s > SIZE_MAX) s = SIZE_MAX;
        return s;
    endfunction

    function automatic logic [8:0] magnitude(input logic [7:0] b, input logic neg,
                                             input logic ovf);
        logic [7:0] m;
        m = neg ? (8'd0 - b) : b;
        return {1'b0, m} + (ovf ? 9'd255 : 9'd0);
    endfunction

    function automatic logic [POS_BITS-1:0] clamp(input logic signed [S-1:0] v,
                                                  input logic [CFG_BITS-1:0] size,
                                                  input logic [CFG_BITS-1:0] margin);
        logic signed [S-1:0] lim;
        logic [CFG_BITS-1:0] top;
        lim = $signed(S'(size)) - $signed(S'(margin));
        top = size - CFG_BITS'(1);
        if (v < 0) return '0;
        if (v > lim) return POS_BITS'(top[11:0]);
        return v[POS_BITS-1:0];
    endfunction

    always_comb begin
        w_sat = sat_size(i_width, WIDTH_MIN);
        h_sat = sat_size(i_height, HEIGHT_MIN);
        x_mag = magnitude(i_pkt.xb, i_pkt.hdr[HDR_XSIGN], i_pkt.hdr[HDR_XOVF]);
        y_mag = magnitude(i_pkt.yb, i_pkt.hdr[HDR_YSIGN], i_pkt.hdr[HDR_YOVF]);
        x_sum = i_pkt.hdr[HDR_XSIGN] ? $signed(S'(r_pos_x)) - $signed(S'(x_mag))
                                     : $signed(S'(r_pos_x)) + $signed(S'(x_mag));
        y_sum = i_pkt.hdr[HDR_YSIGN] ? $signed(S'(r_pos_y)) + $signed(S'(y_mag))
                                     : $signed(S'(r_pos_y)) - $signed(S'(y_mag));
        n_pos_x = clamp(x_sum, w_sat, CFG_BITS'(X_MARGIN));
        n_pos_y = clamp(y_sum, h_sat, CFG_BITS'(Y_MARGIN));
        o_res.cursor_x = n_pos_x[11:0];
        o_res.cursor_y = n_pos_y[11:0];
        o_res.left     = i_pkt.hdr[HDR_LEFT];
        o_res.right    = i_pkt.hdr[HDR_RIGHT];
        o_res.middle   = i_pkt.hdr[HDR_MIDDLE];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
        end else if (i_fire) begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
        end
    end
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for ps2_mouse_packet_tracker: drives mouse bytes with random gaps and
// checks every cursor result against an in-bench tracker of framing, deltas and
// clamping. Depends on pmt_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_top;
    import pmt_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 12;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        pop = 1'b0;
    logic        cfg_we = 1'b0;
    logic [IDX_BITS-1:0] cfg_idx = CFG_WIDTH;
    logic [CFG_BITS-1:0] cfg_data = '0;
    wire         full;
    wire         empty;
    wire  [11:0] cursor_x;
    wire  [11:0] cursor_y;
    wire         left_button;
    wire         right_button;
    wire         middle_button;

    t_phase      rx_phase = PH_SKIP;
    logic [7:0]  header_seen = 8'h00;
    logic [7:0]  x_move_byte = 8'h00;
    int          track_x = 0;
    int          track_y = 0;
    logic [CFG_BITS-1:0] width_reg = WIDTH_RST;
    logic [CFG_BITS-1:0] height_reg = HEIGHT_RST;
    t_res        cursor_q[$];
    int          errors = 0;
    int          cycles = 0;
    int          pop_hold = 0;
    bit          pop_stalls = 1'b1;
    bit          push_gaps = 1'b1;

    ps2_mouse_packet_tracker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_data_byte     (data_byte),
        .empty           (empty),
        .pop             (pop),
        .o_cursor_x      (cursor_x),
        .o_cursor_y      (cursor_y),
        .o_left_button   (left_button),
        .o_right_button  (right_button),
        .o_middle_button (middle_button),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("ps2_mouse_packet_tracker regression: fail");
            $finish;
        end
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int screen_size(logic [CFG_BITS-1:0] v, int lo);
        int s;
        s = v;
        if (s < lo) s = lo;
        if (s > SIZE_MAX) s = SIZE_MAX;
        return s;
    endfunction

    function automatic int axis_move(logic [7:0] b, bit neg, bit ovf);
        logic [7:0] mag_byte;
        int mag;
        mag_byte = neg ? 8'd0 - b : b;
        mag = mag_byte;
        if (ovf) mag += 255;
        return neg ? -mag : mag;
    endfunction

    function automatic int clamp_axis(int v, int size, int margin);
        if (v < 0) v = 0;
        if (v > size - margin) v = size - 1;
        return v;
    endfunction

    function automatic void track_byte(logic [7:0] b);
        int w, h, x, y;
        t_res res;
        case (rx_phase)
            PH_SKIP: rx_phase = PH_HDR;
            PH_HDR: begin
                if (b[HDR_SYNC]) begin
                    header_seen = b;
                    rx_phase = PH_X;
                end
            end
            PH_X: begin
                x_move_byte = b;
                rx_phase = PH_Y;
            end
            PH_Y: begin
                rx_phase = PH_HDR;
                w = screen_size(width_reg, int'(WIDTH_MIN));
                h = screen_size(height_reg, int'(HEIGHT_MIN));
                x = track_x + axis_move(x_move_byte, header_seen[HDR_XSIGN],
                                        header_seen[HDR_XOVF]);
                y = track_y - axis_move(b, header_seen[HDR_YSIGN], header_seen[HDR_YOVF]);
                x = clamp_axis(x, w, int'(X_MARGIN));
                y = clamp_axis(y, h, int'(Y_MARGIN));
                track_x = x & 16'h3FFF;
                track_y = y & 16'h3FFF;
                res.cursor_x = track_x[11:0];
                res.cursor_y = track_y[11:0];
                res.left = header_seen[HDR_LEFT];
                res.right = header_seen[HDR_RIGHT];
                res.middle = header_seen[HDR_MIDDLE];
                cursor_q.push_back(res);
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && !empty && pop) begin
            if (cursor_q.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d buttons=%b%b%b", $time,
                         cursor_x, cursor_y, left_button, right_button, middle_button);
                errors++;
            end else begin
                want = cursor_q.pop_front();
                check_field("cursor_x", want.cursor_x, cursor_x);
                check_field("cursor_y", want.cursor_y, cursor_y);
                check_field("left_button", want.left, left_button);
                check_field("right_button", want.right, right_button);
                check_field("middle_button", want.middle, middle_button);
            end
        end
    end

    // hold pop low for random stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop_hold != 0) begin
            pop <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else begin
            pop <= 1'b1;
            if (pop_stalls) pop_hold <= gap_length();
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        bit was_full;
        gap = push_gaps ? gap_length() : 0;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        data_byte <= b;
        do begin
            @(negedge i_clk);
            was_full = full;
            @(posedge i_clk);
        end while (was_full);
        track_byte(b);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (cursor_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
        while (rx_phase inside {PH_X, PH_Y}) send_byte(8'($urandom));
        drain_results();
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WIDTH)
            width_reg = val;
        else if (idx == CFG_HEIGHT)
            height_reg = val;
    endtask

    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] xb,
                               input logic [7:0] yb);
        send_byte(hdr);
        send_byte(xb);
        send_byte(yb);
    endtask

    task automatic run_traffic(input int n_items);
        int sent, r;
        logic [7:0] hdr, xb, yb;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 80) begin
                hdr = 8'($urandom) | 8'h08;
                xb = 8'($urandom);
                yb = 8'($urandom);
                // small moves keep the cursor off the edges
                if ($urandom_range(1) == 0) begin
                    hdr[HDR_XOVF] = 1'b0;
                    hdr[HDR_YOVF] = 1'b0;
                    xb = hdr[HDR_XSIGN] ? 8'(-$urandom_range(0, 20)) : 8'($urandom_range(0, 20));
                    yb = hdr[HDR_YSIGN] ? 8'(-$urandom_range(0, 20)) : 8'($urandom_range(0, 20));
                end
                send_packet(hdr, xb, yb);
                sent += 3;
            end else if (r < 92) begin
                send_byte(8'($urandom) & 8'hF7);
            end else begin
                send_byte(8'($urandom));
                sent++;
            end
        end
    endtask

    task automatic test_framing_and_deltas();
        logic [7:0] seq[] = '{
            8'h08, 8'h00,
            8'h09, 8'h7F, 8'h00,
            8'h4A, 8'hFF, 8'h00,
            8'h1C, 8'h00, 8'h00,
            8'h58, 8'h00, 8'h00,
            8'h28, 8'h00, 8'h00,
            8'hA8, 8'h00, 8'h01,
            8'h88, 8'h00, 8'hFF,
            8'hFF, 8'h80, 8'h80
        };
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic test_unused_register_index();
        write_reg(2'd2, 13'h1FFF);
        write_reg(2'd3, 13'h0000);
        send_packet(8'h58, 8'h00, 8'h00);
        send_packet(8'h0F, 8'h40, 8'hC0);
    endtask

    task automatic test_screen_sizes();
        logic [CFG_BITS-1:0] w, h;
        for (int k = 0; k < 8; k++) begin
            case (k)
                0: begin w = WIDTH_RST; h = HEIGHT_RST; end
                1: begin w = WIDTH_MIN; h = HEIGHT_MIN; end
                2: begin w = SIZE_MAX; h = SIZE_MAX; end
                3: begin w = 13'd0; h = 13'd0; end
                4: begin w = 13'h1FFF; h = 13'h1FFF; end
                5: begin w = 13'd15; h = 13'd23; end
                6: begin w = 13'd4097; h = 13'd25; end
                default: begin
                    w = 13'($urandom_range(16, 4096));
                    h = 13'($urandom_range(24, 4096));
                end
            endcase
            write_reg(CFG_WIDTH, w);
            write_reg(CFG_HEIGHT, h);
            pop_stalls = (k != 2) && (k != 5);
            push_gaps = (k != 2) && (k != 3);
            run_traffic(205);
        end
        pop_stalls = 1'b1;
        push_gaps = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_framing_and_deltas();
        test_unused_register_index();
        test_screen_sizes();
        drain_results();
        if (errors == 0)
            $display("ps2_mouse_packet_tracker regression: pass");
        else
            $display("ps2_mouse_packet_tracker regression: fail");
        $finish;
    end

endmodule
